[hdl/assert_macros.svh]
// Assertion helpers for the RTL files; rsgap_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/rsgap_pkg.sv]
package rsgap_pkg;

  // Command codes
  localparam logic [2:0] CMD_RX_BYTE = 3'd0;
  localparam logic [2:0] CMD_TICK    = 3'd1;
  localparam logic [2:0] CMD_READ    = 3'd2;
  localparam logic [2:0] CMD_RELEASE = 3'd3;
  localparam logic [2:0] CMD_TX_REQ  = 3'd4;
  localparam logic [2:0] CMD_TX_DONE = 3'd5;

  // Link modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_TX   = 2'd1;
  localparam logic [1:0] MODE_RX   = 2'd2;

  // Register indexes
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_GAP_TICKS = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_LEN   = 1'b1;

  // Reset values
  localparam logic [7:0] GAP_RESET    = 8'h03;
  localparam logic [7:0] MAXLEN_RESET = 8'd99;
  localparam logic [7:0] TIMER_RESET  = 8'd2;

  // Status of one step, without the buffer byte
  typedef struct packed {
    logic [1:0] link_state;
    logic       driver_enable;
    logic       frame_closed;
    logic [7:0] closed_len;
    logic [7:0] head_len;
    logic       tx_granted;
    logic       byte_dropped;
    logic       bus_free;
    logic       rd_hit;
  } res_t;

endpackage

[hdl/rsgap_if.sv]
// Command channel
interface rsgap_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] rx_data;
  logic [6:0] read_index;

  modport source (output valid, cmd, rx_data, read_index, input ready);
  modport sink   (input valid, cmd, rx_data, read_index, output ready);
endinterface

// Status channel
interface rsgap_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] link_state;
  logic       driver_enable;
  logic       frame_closed;
  logic [7:0] closed_len;
  logic [7:0] head_len;
  logic [7:0] read_data;
  logic       tx_granted;
  logic       byte_dropped;
  logic       bus_free;

  modport source (output valid, link_state, driver_enable, frame_closed, closed_len,
                  head_len, read_data, tx_granted, byte_dropped, bus_free, input ready);
  modport sink   (input valid, link_state, driver_enable, frame_closed, closed_len,
                  head_len, read_data, tx_granted, byte_dropped, bus_free, output ready);
endinterface

[hdl/rsgap_store.sv]
module rsgap_store #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // Write a stored byte, register a read; hold the read data between reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/rsgap_ctrl.sv]
module rsgap_ctrl #(
  parameter int unsigned SLOTS      = 2,
  parameter int unsigned SLOT_BYTES = 128,
  parameter int unsigned ADDR_W     = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rsgap_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  logic [7:0]                         cfg_wdata_i,
  input  logic                               acc_i,
  input  logic [2:0]                         cmd_i,
  input  logic [7:0]                         rx_data_i,
  input  logic [6:0]                         read_index_i,
  output rsgap_pkg::res_t                    res_o,
  output logic                               we_o,
  output logic [ADDR_W-1:0]                  waddr_o,
  output logic [7:0]                         wdata_o,
  output logic                               re_o,
  output logic [ADDR_W-1:0]                  raddr_o
);

  import rsgap_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned SLOT_W      = $clog2(SLOTS);
  localparam logic [8:0]  SlotBytesW  = 9'(SLOT_BYTES);
  localparam logic [ADDR_W-1:0] SlotBytesA = ADDR_W'(SLOT_BYTES);

  logic [7:0]        gap_q, max_len_q;
  logic [7:0]        lengths_q [SLOTS];
  logic [7:0]        lengths_d [SLOTS];
  logic [SLOT_W-1:0] fill_q, fill_d, head_q, head_d;
  logic [7:0]        bc_q, bc_d, timer_q, timer_d;
  logic [1:0]        mode_q, mode_d;

  logic [8:0]        lim, cnt, head_len9;
  logic              closed, granted, dropped, rd_hit;
  logic [7:0]        closed_len;
  logic [SLOT_W-1:0] wslot;
  logic [7:0]        wpos;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    r = ((32'(s) + 32'd1) >= 32'(SLOTS)) ? '0 : s + 1'b1;
    return r;
  endfunction

  // Frame limit in force
  assign lim = (9'(max_len_q) > SlotBytesW) ? SlotBytesW : 9'(max_len_q);
  assign head_len9 = 9'(lengths_q[head_q]);

  // Work out the effect of one item
  always_comb begin
    lengths_d  = lengths_q;
    fill_d     = fill_q;
    head_d     = head_q;
    bc_d       = bc_q;
    timer_d    = timer_q;
    mode_d     = mode_q;
    closed     = 1'b0;
    closed_len = '0;
    granted    = 1'b0;
    dropped    = 1'b0;
    rd_hit     = 1'b0;
    we_o       = 1'b0;
    wslot      = fill_q;
    wpos       = bc_q;
    cnt        = '0;
    if (acc_i) begin
      case (cmd_i)
        CMD_RX_BYTE: begin
          if (mode_q != MODE_TX) begin
            mode_d = MODE_RX;
            if (lengths_q[fill_q] != '0) begin
              dropped = 1'b1;
            end else begin
              // close on a late byte
              if (timer_q == '0 && bc_q != '0) begin
                lengths_d[fill_q] = bc_q;
                closed_len        = bc_q;
                closed            = 1'b1;
                fill_d            = next_slot(fill_q);
                bc_d              = '0;
              end
              if (lengths_d[fill_d] != '0) begin
                dropped = 1'b1;
              end else begin
                we_o    = (9'(bc_d) < SlotBytesW);
                wslot   = fill_d;
                wpos    = bc_d;
                cnt     = 9'(bc_d) + 9'd1;
                bc_d    = cnt[7:0];
                timer_d = gap_q;
                // close at the length limit
                if (cnt >= lim) begin
                  lengths_d[fill_d] = cnt[7:0];
                  closed_len        = cnt[7:0];
                  closed            = 1'b1;
                  fill_d            = next_slot(fill_d);
                  bc_d              = '0;
                  mode_d            = MODE_IDLE;
                end
              end
            end
          end
        end
        CMD_TICK: begin
          if (timer_q != '0) begin
            timer_d = timer_q - 8'd1;
          end else if (mode_q == MODE_RX) begin
            if (bc_q != '0) begin
              lengths_d[fill_q] = bc_q;
              closed_len        = bc_q;
              closed            = 1'b1;
              fill_d            = next_slot(fill_q);
              bc_d              = '0;
            end
            mode_d = MODE_IDLE;
          end
        end
        CMD_READ: begin
          rd_hit = (head_len9 != '0) && (9'(read_index_i) < head_len9) &&
                   (9'(read_index_i) < SlotBytesW);
        end
        CMD_RELEASE: begin
          if (lengths_q[head_q] != '0) begin
            lengths_d[head_q] = '0;
            head_d            = next_slot(head_q);
          end
        end
        CMD_TX_REQ: begin
          if (mode_q == MODE_IDLE && timer_q == '0) begin
            mode_d  = MODE_TX;
            granted = 1'b1;
          end
        end
        CMD_TX_DONE: begin
          if (mode_q == MODE_TX) begin
            mode_d = MODE_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Buffer access
  assign waddr_o = ADDR_W'(wslot) * SlotBytesA + ADDR_W'(wpos);
  assign wdata_o = rx_data_i;
  assign re_o    = rd_hit;
  assign raddr_o = ADDR_W'(head_q) * SlotBytesA + ADDR_W'(read_index_i);

  // Status after the step
  always_comb begin
    res_o.link_state    = mode_d;
    res_o.driver_enable = (mode_d == MODE_TX);
    res_o.frame_closed  = closed;
    res_o.closed_len    = closed_len;
    res_o.head_len      = lengths_d[head_d];
    res_o.tx_granted    = granted;
    res_o.byte_dropped  = dropped;
    res_o.bus_free      = (timer_d == '0);
    res_o.rd_hit        = rd_hit;
  end

  // Hold state; advance on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q     <= GAP_RESET;
      max_len_q <= MAXLEN_RESET;
      for (int i = 0; i < SLOTS; i++) begin
        lengths_q[i] <= '0;
      end
      fill_q    <= '0;
      head_q    <= '0;
      bc_q      <= '0;
      timer_q   <= TIMER_RESET;
      mode_q    <= MODE_IDLE;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GAP_TICKS: gap_q     <= cfg_wdata_i;
          REG_MAX_LEN:   max_len_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      lengths_q <= lengths_d;
      fill_q    <= fill_d;
      head_q    <= head_d;
      bc_q      <= bc_d;
      timer_q   <= timer_d;
      mode_q    <= mode_d;
    end
  end

  `ASSERT_RST(a_tx_bus_quiet, clk_i, rst_ni, mode_q == MODE_TX |-> timer_q == '0, "transmitting while bus timer runs")
  `ASSERT_RST(a_fill_free, clk_i, rst_ni, bc_q != '0 |-> lengths_q[fill_q] == '0, "bytes stored into a pending slot")
  `ASSERT_RST(a_count_fits, clk_i, rst_ni, 9'(bc_q) < SlotBytesW, "byte count past slot size")
  `ASSERT_RST(a_release, clk_i, rst_ni, acc_i && cmd_i == CMD_RELEASE && lengths_q[head_q] != '0 |=> lengths_q[$past(head_q)] == '0, "released slot still pending")

endmodule

[hdl/rs485_idle_gap_frame_receiver.sv]
// RS485 half-duplex receiver that delimits frames by an idle gap.
// in_i carries one command per item: a received byte, a 1 ms tick, a read
// of a byte of the oldest pending frame, a release of that frame, a bus
// request and a transmit-done report. out_o returns one status item for
// every command item, in order.
// Registers gap_ticks and max_frame_len are written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i; the user must write them only while no item
// is in flight, as the block does not enforce it. The status item is
// registered at the edge that accepts the command, and the buffer read for
// a byte read is taken from the frame memory at that same edge. One item is
// accepted every cycle unless out_o stalls; the single read-modify-write of
// the slot length words and one memory port access per item set that rate.
// in_i.ready follows out_o: a new item is taken when no status waits or the
// waiting one is taken in the same cycle; a stalled status item holds.
// Reset clears all length words (no frame pending), the slot pointers, the
// byte count and the mode, and loads the gap timer with two ticks. The frame
// memory is not cleared; bytes beyond a frame's length are never returned.
module rs485_idle_gap_frame_receiver #(
  parameter int unsigned SLOTS      = 2,
  parameter int unsigned SLOT_BYTES = 128
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rsgap_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                      cfg_wdata_i,
  rsgap_in_if.sink                        in_i,
  rsgap_out_if.source                     out_o
);

  import rsgap_pkg::*;

  localparam int unsigned DEPTH  = SLOTS * SLOT_BYTES;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic              acc;
  logic              out_valid_q;
  res_t              res, res_q;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wdata, rdata;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;

  rsgap_ctrl #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .acc_i        (acc),
    .cmd_i        (in_i.cmd),
    .rx_data_i    (in_i.rx_data),
    .read_index_i (in_i.read_index),
    .res_o        (res),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .re_o         (re),
    .raddr_o      (raddr)
  );

  rsgap_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Track the status register's valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Capture status of each accepted item
  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.link_state    = res_q.link_state;
  assign out_o.driver_enable = res_q.driver_enable;
  assign out_o.frame_closed  = res_q.frame_closed;
  assign out_o.closed_len    = res_q.closed_len;
  assign out_o.head_len      = res_q.head_len;
  assign out_o.read_data     = res_q.rd_hit ? rdata : 8'd0;
  assign out_o.tx_granted    = res_q.tx_granted;
  assign out_o.byte_dropped  = res_q.byte_dropped;
  assign out_o.bus_free      = res_q.bus_free;

endmodule

[tb/tb.sv]
module tb;
  import rsgap_pkg::*;

  // One command as it travels on the command channel
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] rx;
    logic [6:0] ridx;
  } link_cmd_t;

  // One status item as the block reports it
  typedef struct packed {
    logic [1:0] link_state;
    logic       driver_enable;
    logic       frame_closed;
    logic [7:0] closed_len;
    logic [7:0] head_len;
    logic [7:0] read_data;
    logic       tx_granted;
    logic       byte_dropped;
    logic       bus_free;
  } link_status_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we;
  logic [0:0] cfg_idx;
  logic [7:0] cfg_wdata;

  rsgap_in_if  cmd_if ();
  rsgap_out_if status_if ();

  rs485_idle_gap_frame_receiver i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (cmd_if),
    .out_o       (status_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver state kept by the testbench
  logic [7:0]   rx_store [256];
  logic [7:0]   slot_len [2];
  logic         fill_ptr;
  logic         head_ptr;
  logic [7:0]   rx_count;
  logic [7:0]   silence_timer;
  logic [1:0]   link_mode;
  logic [7:0]   gap_setting;
  logic [7:0]   len_setting;

  link_cmd_t    cmd_backlog [$];
  link_status_t pending_status [$];
  link_cmd_t    next_cmd;
  link_status_t want;
  int unsigned  queued_total;
  int unsigned  mismatches;
  int           burst_left;
  int           pause_left;
  logic [31:0]  sink_cycle;

  // Close the frame being filled and move to the next slot
  function automatic logic [7:0] seal_frame();
    logic [7:0] len;
    len = rx_count;
    slot_len[fill_ptr] = len;
    fill_ptr = ~fill_ptr;
    rx_count = 8'd0;
    return len;
  endfunction

  // Advance the receiver by one command and return its status
  function automatic link_status_t apply_cmd(link_cmd_t c);
    link_status_t s;
    logic [7:0]   limit;
    s = '0;
    limit = (len_setting > 8'd128) ? 8'd128 : len_setting;
    case (c.cmd)
      CMD_RX_BYTE: begin
        if (link_mode != MODE_TX) begin
          link_mode = MODE_RX;
          if (slot_len[fill_ptr] != 8'd0) begin
            s.byte_dropped = 1'b1;
          end else begin
            // a byte after the gap ran out closes the frame before it
            if (silence_timer == 8'd0 && rx_count != 8'd0) begin
              s.closed_len = seal_frame();
              s.frame_closed = 1'b1;
            end
            if (slot_len[fill_ptr] != 8'd0) begin
              s.byte_dropped = 1'b1;
            end else begin
              if (rx_count < 8'd128) rx_store[{fill_ptr, rx_count[6:0]}] = c.rx;
              rx_count = rx_count + 8'd1;
              silence_timer = gap_setting;
              if (rx_count >= limit) begin
                s.closed_len = seal_frame();
                s.frame_closed = 1'b1;
                link_mode = MODE_IDLE;
              end
            end
          end
        end
      end
      CMD_TICK: begin
        if (silence_timer != 8'd0) begin
          silence_timer = silence_timer - 8'd1;
        end else if (link_mode == MODE_RX) begin
          if (rx_count != 8'd0) begin
            s.closed_len = seal_frame();
            s.frame_closed = 1'b1;
          end
          link_mode = MODE_IDLE;
        end
      end
      CMD_READ: begin
        if (slot_len[head_ptr] != 8'd0 && {1'b0, c.ridx} < slot_len[head_ptr])
          s.read_data = rx_store[{head_ptr, c.ridx}];
      end
      CMD_RELEASE: begin
        if (slot_len[head_ptr] != 8'd0) begin
          slot_len[head_ptr] = 8'd0;
          head_ptr = ~head_ptr;
        end
      end
      CMD_TX_REQ: begin
        if (link_mode == MODE_IDLE && silence_timer == 8'd0) begin
          link_mode = MODE_TX;
          s.tx_granted = 1'b1;
        end
      end
      CMD_TX_DONE: begin
        if (link_mode == MODE_TX) link_mode = MODE_IDLE;
      end
      default: ;
    endcase
    s.link_state = link_mode;
    s.driver_enable = (link_mode == MODE_TX);
    s.head_len = slot_len[head_ptr];
    s.bus_free = (silence_timer == 8'd0);
    return s;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  task automatic queue_cmd(logic [2:0] c, logic [7:0] d, logic [6:0] idx);
    cmd_backlog.push_back({c, d, idx});
    queued_total++;
  endtask

  task automatic queue_ticks(int n);
    repeat (n) queue_cmd(CMD_TICK, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
  endtask

  task automatic queue_frame(int n);
    repeat (n) queue_cmd(CMD_RX_BYTE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
  endtask

  // Read a few bytes of the head frame, some past its end, then free it
  task automatic queue_readout(int n);
    int top;
    top = (n + 1 > 127) ? 127 : n + 1;
    repeat ($urandom_range(1, 4))
      queue_cmd(CMD_READ, 8'($urandom_range(0, 255)), 7'($urandom_range(0, top)));
    queue_cmd(CMD_RELEASE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
  endtask

  // Mostly well-formed frame traffic, with broken sequences and noise mixed in
  task automatic queue_traffic(int gap, int items);
    int stop;
    int pick;
    int len;
    int len2;
    stop = int'(queued_total) + items;
    while (int'(queued_total) < stop) begin
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
      len2 = $urandom_range(1, 6);
      if (pick < 55) begin
        // clean frame, gap expiry, readout, sometimes a transmit turn
        queue_frame(len);
        queue_ticks(gap + 1 + $urandom_range(0, 1));
        queue_readout(len);
        if ($urandom_range(0, 2) == 0) begin
          queue_cmd(CMD_TX_REQ, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
          if ($urandom_range(0, 1) == 0) queue_frame(1);
          queue_cmd(CMD_TX_DONE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
        end
      end else if (pick < 70) begin
        // second frame starts with a late byte
        queue_frame(len);
        queue_ticks(gap);
        queue_frame(len2);
        queue_ticks(gap + 1);
        queue_readout(len);
        queue_readout(len2);
      end else if (pick < 80) begin
        // frame left unreleased so the ring fills up
        queue_frame(len);
        queue_ticks(gap + 1);
      end else if (pick < 88) begin
        // short pause inside a frame, under the gap
        queue_frame(len2);
        queue_ticks($urandom_range(0, gap - 1));
        queue_frame(len2);
        queue_ticks(gap + 1);
        queue_readout(2 * len2);
      end else begin
        repeat ($urandom_range(1, 6))
          queue_cmd(3'($urandom_range(0, 5)), 8'($urandom_range(0, 255)),
                    7'($urandom_range(0, 127)));
      end
    end
  endtask

  // Hold until every command is sent and every status item is back
  task automatic wait_drained();
    @(negedge clk_i);
    while (cmd_backlog.size() != 0 || cmd_if.valid || pending_status.size() != 0)
      @(negedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_GAP_TICKS) gap_setting = val;
    else len_setting = val;
  endtask

  task automatic run_phase(logic [7:0] gap, logic [7:0] maxlen, int items);
    wait_drained();
    write_reg(REG_GAP_TICKS, gap);
    write_reg(REG_MAX_LEN, maxlen);
    queue_traffic(gap, items);
  endtask

  // Sender: offer items from the backlog in bursts with pauses between
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
      burst_left <= 0;
      pause_left <= 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready)
        pending_status.push_back(apply_cmd({cmd_if.cmd, cmd_if.rx_data, cmd_if.read_index}));
      if (!cmd_if.valid || cmd_if.ready) begin
        if (pause_left != 0 || cmd_backlog.size() == 0) begin
          cmd_if.valid <= 1'b0;
          if (pause_left != 0) pause_left <= pause_left - 1;
        end else begin
          next_cmd = cmd_backlog.pop_front();
          cmd_if.valid <= 1'b1;
          cmd_if.cmd <= next_cmd.cmd;
          cmd_if.rx_data <= next_cmd.rx;
          cmd_if.read_index <= next_cmd.ridx;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            pause_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver: stall on a pattern that changes with sink_cycle, check status items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_if.ready <= 1'b0;
      sink_cycle <= '0;
    end else begin
      sink_cycle <= sink_cycle + 1;
      case (sink_cycle[9:8])
        2'd0:    status_if.ready <= 1'b1;
        2'd1:    status_if.ready <= ($urandom_range(0, 3) != 0);
        2'd2:    status_if.ready <= (sink_cycle[2:1] != 2'd0);
        default: status_if.ready <= 1'($urandom_range(0, 1));
      endcase
      if (status_if.valid && status_if.ready) begin
        if (pending_status.size() == 0) begin
          $error("status item with no command waiting");
          mismatches++;
        end else begin
          want = pending_status.pop_front();
          check_field("link_state", 32'(want.link_state), 32'(status_if.link_state));
          check_field("driver_enable", 32'(want.driver_enable),
                      32'(status_if.driver_enable));
          check_field("frame_closed", 32'(want.frame_closed), 32'(status_if.frame_closed));
          check_field("closed_len", 32'(want.closed_len), 32'(status_if.closed_len));
          check_field("head_len", 32'(want.head_len), 32'(status_if.head_len));
          check_field("read_data", 32'(want.read_data), 32'(status_if.read_data));
          check_field("tx_granted", 32'(want.tx_granted), 32'(status_if.tx_granted));
          check_field("byte_dropped", 32'(want.byte_dropped), 32'(status_if.byte_dropped));
          check_field("bus_free", 32'(want.bus_free), 32'(status_if.bus_free));
        end
      end
    end
  end

  initial begin
    cfg_we = 1'b0;
    cfg_idx = REG_GAP_TICKS;
    cfg_wdata = 8'd0;
    cmd_if.valid = 1'b0;
    cmd_if.cmd = CMD_TICK;
    cmd_if.rx_data = 8'd0;
    cmd_if.read_index = 7'd0;
    status_if.ready = 1'b0;
    queued_total = 0;
    mismatches = 0;
    for (int i = 0; i < 256; i++) rx_store[i] = 8'd0;
    slot_len[0] = 8'd0;
    slot_len[1] = 8'd0;
    fill_ptr = 1'b0;
    head_ptr = 1'b0;
    rx_count = 8'd0;
    silence_timer = TIMER_RESET;
    link_mode = MODE_IDLE;
    gap_setting = GAP_RESET;
    len_setting = MAXLEN_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: bus turnaround, refused requests, late byte, expiry, full ring
    queue_cmd(CMD_TX_DONE, 8'h00, 7'd0);
    queue_cmd(CMD_TX_REQ, 8'h00, 7'd0);
    queue_ticks(3);
    queue_cmd(CMD_TX_REQ, 8'hFF, 7'h7F);
    queue_cmd(CMD_RX_BYTE, 8'h5A, 7'd0);
    queue_cmd(CMD_TX_REQ, 8'h00, 7'd0);
    queue_cmd(CMD_TX_DONE, 8'h00, 7'd0);
    queue_cmd(CMD_RELEASE, 8'h00, 7'd0);
    queue_cmd(CMD_READ, 8'h00, 7'h7F);
    queue_cmd(CMD_RX_BYTE, 8'h00, 7'd0);
    queue_cmd(CMD_RX_BYTE, 8'hFF, 7'h7F);
    queue_ticks(3);
    queue_cmd(CMD_RX_BYTE, 8'hA5, 7'd0);
    queue_ticks(4);
    queue_cmd(CMD_RX_BYTE, 8'h3C, 7'd0);
    queue_ticks(1);
    queue_cmd(CMD_READ, 8'h00, 7'd0);
    queue_cmd(CMD_READ, 8'h00, 7'd1);
    queue_cmd(CMD_READ, 8'h00, 7'd2);
    queue_cmd(CMD_RELEASE, 8'h00, 7'd0);
    queue_cmd(CMD_READ, 8'h00, 7'd0);
    queue_cmd(CMD_RELEASE, 8'h00, 7'd0);

    // Random traffic over several register settings, extremes included
    run_phase(8'd1, 8'd128, 150);
    run_phase(8'd255, 8'd1, 100);
    run_phase(8'd5, 8'd3, 200);
    run_phase(8'($urandom_range(1, 12)), 8'($urandom_range(1, 128)), 200);
    run_phase(8'd2, 8'd128, 150);
    run_phase(8'd12, 8'd16, 150);
    wait_drained();
    repeat (5) @(posedge clk_i);

    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
